@@ hdl/kstt_pkg.sv @@
`default_nettype none

package kstt_pkg;

  localparam int unsigned SlotsDef     = 16;
  localparam int unsigned MaxTrialsDef = 16;
  localparam int unsigned SetSizeDef   = 3;

  localparam int unsigned OpW       = 3;
  localparam int unsigned KeyW      = 32;
  localparam int unsigned RcW       = 5;
  localparam int unsigned IdxOutW   = 4;
  localparam int unsigned TrOutW    = 5;
  localparam int unsigned FirstOutW = 4;
  localparam int unsigned TotW      = 9;

  typedef enum logic [OpW-1:0] {
    OP_REGISTER   = 3'd0,
    OP_APPEND     = 3'd1,
    OP_CAN_APPEND = 3'd2,
    OP_RESTORE    = 3'd3,
    OP_REMOVE     = 3'd4,
    OP_CLEAR      = 3'd5,
    OP_FIND       = 3'd6,
    OP_TOTAL      = 3'd7
  } opcode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_EXEC
  } state_e;

endpackage

`default_nettype wire

@@ hdl/kstt_ram.sv @@
`default_nettype none

module kstt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ hdl/keyed_slot_trial_table_unit.sv @@
// A command accepted in idle runs through the scan, drain and execute states in order;
// done_o is registered from execute. Busy drops in the strobe cycle, and a new command
// is taken only in idle. The scan reads one slot per cycle via the key/count RAM port.
// The receiver cannot stall: each result is shown for exactly one cycle on done_o.
// Reset (async, active low) frees all slots at once through per-slot active flags.
`default_nettype none

module keyed_slot_trial_table_unit
  import kstt_pkg::*;
#(
  parameter int unsigned SLOTS      = SlotsDef,
  parameter int unsigned MAX_TRIALS = MaxTrialsDef,
  parameter int unsigned SET_SIZE   = SetSizeDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [OpW-1:0]       opcode_i,
  input  wire logic [KeyW-1:0]      key_id_i,
  input  wire logic [RcW-1:0]       restore_count_i,
  output logic                      done_o,
  output logic                      ok_o,
  output logic [IdxOutW-1:0]        slot_index_o,
  output logic [TrOutW-1:0]         slot_trials_o,
  output logic [FirstOutW-1:0]      first_trial_o,
  output logic [TotW-1:0]           total_trials_o
);

  localparam int unsigned IW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW   = $clog2(MAX_TRIALS + 1);
  localparam int unsigned SUMW = CW + 5;
  localparam int unsigned RCMW = (CW > RcW) ? CW : RcW;

  state_e state_q, state_d;

  logic             scan_rd;
  logic             exec_en;
  logic             accept;

  logic [IW-1:0]    addr_q;
  logic             chk_v_q;
  logic [IW-1:0]    chk_idx_q;

  opcode_e          op_q;
  logic [KeyW-1:0]  key_q;
  logic [RcW-1:0]   rc_q;

  logic [SLOTS-1:0] active_q;

  logic             match_v_q;
  logic [IW-1:0]    match_idx_q;
  logic [CW-1:0]    match_cnt_q;
  logic             free_v_q;
  logic [IW-1:0]    free_idx_q;
  logic [TotW-1:0]  total_q;

  logic [KeyW-1:0]  key_rdata;
  logic [CW-1:0]    cnt_rdata;
  logic             chk_act;
  logic [CW-1:0]    chk_cnt;

  // execute-stage decode
  logic             tgt_v;
  logic [IW-1:0]    tgt_idx;
  logic [CW-1:0]    tgt_cnt;
  logic [SUMW-1:0]  tgt_sum;
  logic [SUMW-1:0]  match_sum;
  logic             rc_good;

  logic             wr_en;
  logic [CW-1:0]    wr_cnt;
  logic             act_set;
  logic             act_clr;
  logic             act_clr_all;

  logic             res_ok;
  logic [IW-1:0]    res_idx;
  logic [CW-1:0]    res_trials;
  logic [CW-1:0]    res_first;
  logic [TotW-1:0]  res_total;

  logic [IW+IdxOutW-1:0]  idx_ext;
  logic [CW+TrOutW-1:0]   tr_ext;
  logic [CW+FirstOutW-1:0] first_ext;

  assign accept = start && !busy;

  // ---------------- sequencer ----------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (start) state_d = ST_SCAN;
      ST_SCAN:  if (addr_q == IW'(SLOTS - 1)) state_d = ST_DRAIN;
      ST_DRAIN: state_d = ST_EXEC;
      ST_EXEC:  state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    busy    = 1'b1;
    scan_rd = 1'b0;
    exec_en = 1'b0;
    unique case (state_q)
      ST_IDLE:  busy    = 1'b0;
      ST_SCAN:  scan_rd = 1'b1;
      ST_DRAIN: ;
      ST_EXEC:  exec_en = 1'b1;
      default:  busy    = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      chk_v_q <= 1'b0;
      done_o  <= 1'b0;
    end else begin
      state_q <= state_d;
      chk_v_q <= scan_rd;
      done_o  <= exec_en;
    end
  end

  // ---------------- storage ----------------
  kstt_ram #(
    .Width (KeyW),
    .Depth (SLOTS)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (tgt_idx),
    .wdata_i (key_q),
    .re_i    (scan_rd),
    .raddr_i (addr_q),
    .rdata_o (key_rdata)
  );

  kstt_ram #(
    .Width (CW),
    .Depth (SLOTS)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (tgt_idx),
    .wdata_i (wr_cnt),
    .re_i    (scan_rd),
    .raddr_i (addr_q),
    .rdata_o (cnt_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
    end else if (act_clr_all) begin
      active_q <= '0;
    end else if (act_set) begin
      active_q[tgt_idx] <= 1'b1;
    end else if (act_clr) begin
      active_q[tgt_idx] <= 1'b0;
    end
  end

  // ---------------- scan datapath ----------------
  assign chk_act = active_q[chk_idx_q];
  assign chk_cnt = chk_act ? cnt_rdata : '0;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q        <= opcode_e'(opcode_i);
      key_q       <= key_id_i;
      rc_q        <= restore_count_i;
      addr_q      <= '0;
      match_v_q   <= 1'b0;
      free_v_q    <= 1'b0;
      total_q     <= '0;
      match_idx_q <= '0;
      match_cnt_q <= '0;
      free_idx_q  <= '0;
    end else begin
      if (scan_rd) begin
        chk_idx_q <= addr_q;
        addr_q    <= addr_q + IW'(1);
      end
      if (chk_v_q) begin
        if (chk_act && (key_rdata == key_q) && !match_v_q) begin
          match_v_q   <= 1'b1;
          match_idx_q <= chk_idx_q;
          match_cnt_q <= chk_cnt;
        end
        if (!chk_act && !free_v_q) begin
          free_v_q   <= 1'b1;
          free_idx_q <= chk_idx_q;
        end
        total_q <= total_q + {{(TotW-CW){1'b0}}, chk_cnt};
      end
    end
  end

  // ---------------- execute ----------------
  assign tgt_v     = match_v_q || free_v_q;
  assign tgt_idx   = match_v_q ? match_idx_q : free_idx_q;
  assign tgt_cnt   = match_v_q ? match_cnt_q : '0;
  assign tgt_sum   = {{(SUMW-CW){1'b0}}, tgt_cnt} + SUMW'(SET_SIZE);
  assign match_sum = {{(SUMW-CW){1'b0}}, match_cnt_q} + SUMW'(SET_SIZE);
  assign rc_good   = (rc_q != '0) && (RCMW'(rc_q) <= RCMW'(MAX_TRIALS));

  always_comb begin
    wr_en       = 1'b0;
    wr_cnt      = '0;
    act_set     = 1'b0;
    act_clr     = 1'b0;
    act_clr_all = 1'b0;
    res_ok      = 1'b0;
    res_idx     = '0;
    res_trials  = '0;
    res_first   = '0;
    res_total   = '0;
    unique case (op_q)
      OP_REGISTER: begin
        if (tgt_v) begin
          wr_en      = 1'b1;
          wr_cnt     = CW'(1);
          act_set    = 1'b1;
          res_ok     = 1'b1;
          res_idx    = tgt_idx;
          res_trials = CW'(1);
        end
      end
      OP_APPEND: begin
        if (tgt_v && (tgt_sum <= SUMW'(MAX_TRIALS))) begin
          wr_en      = 1'b1;
          wr_cnt     = tgt_sum[CW-1:0];
          act_set    = 1'b1;
          res_ok     = 1'b1;
          res_idx    = tgt_idx;
          res_trials = tgt_sum[CW-1:0];
          res_first  = tgt_cnt;
        end
      end
      OP_CAN_APPEND: begin
        if (match_v_q) begin
          if (match_sum <= SUMW'(MAX_TRIALS)) begin
            res_ok     = 1'b1;
            res_idx    = match_idx_q;
            res_trials = match_cnt_q;
            res_first  = match_cnt_q;
          end
        end else if (free_v_q) begin
          res_ok  = 1'b1;
          res_idx = free_idx_q;
        end
      end
      OP_RESTORE: begin
        if (rc_good && tgt_v) begin
          wr_en      = 1'b1;
          wr_cnt     = CW'(rc_q);
          act_set    = 1'b1;
          res_ok     = 1'b1;
          res_idx    = tgt_idx;
          res_trials = CW'(rc_q);
        end
      end
      OP_REMOVE: begin
        if (match_v_q) begin
          act_clr = 1'b1;
          res_ok  = 1'b1;
          res_idx = match_idx_q;
        end
      end
      OP_CLEAR: begin
        act_clr_all = 1'b1;
        res_ok      = 1'b1;
      end
      OP_FIND: begin
        if (match_v_q) begin
          res_ok     = 1'b1;
          res_idx    = match_idx_q;
          res_trials = match_cnt_q;
        end
      end
      OP_TOTAL: begin
        res_ok    = 1'b1;
        res_total = total_q;
      end
      default: ;
    endcase
    if (!exec_en) begin
      wr_en       = 1'b0;
      act_set     = 1'b0;
      act_clr     = 1'b0;
      act_clr_all = 1'b0;
    end
  end

  assign idx_ext   = {{IdxOutW{1'b0}}, res_idx};
  assign tr_ext    = {{TrOutW{1'b0}}, res_trials};
  assign first_ext = {{FirstOutW{1'b0}}, res_first};

  always_ff @(posedge clk_i) begin
    if (exec_en) begin
      ok_o           <= res_ok;
      slot_index_o   <= idx_ext[IdxOutW-1:0];
      slot_trials_o  <= tr_ext[TrOutW-1:0];
      first_trial_o  <= first_ext[FirstOutW-1:0];
      total_trials_o <= res_total;
    end
  end

endmodule

`default_nettype wire

@@ sim/keyed_slot_trial_table_unit_tb.sv @@
`timescale 1ns / 1ps

module keyed_slot_trial_table_unit_tb;
  import kstt_pkg::*;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned SettleCycles  = SlotsDef + 8;
  localparam int unsigned KeyPoolSize   = 24;
  localparam int unsigned ItemsPerPhase = 500;

  typedef struct packed {
    logic                 ok;
    logic [IdxOutW-1:0]   idx;
    logic [TrOutW-1:0]    trials;
    logic [FirstOutW-1:0] first;
    logic [TotW-1:0]      total;
  } outcome_t;

  logic                 clk_i           = 1'b0;
  logic                 rst_ni          = 1'b0;
  logic                 start           = 1'b0;
  opcode_e              opcode_i        = OP_TOTAL;
  logic [KeyW-1:0]      key_id_i        = '0;
  logic [RcW-1:0]       restore_count_i = '0;
  logic                 busy;
  logic                 done_o;
  logic                 ok_o;
  logic [IdxOutW-1:0]   slot_index_o;
  logic [TrOutW-1:0]    slot_trials_o;
  logic [FirstOutW-1:0] first_trial_o;
  logic [TotW-1:0]      total_trials_o;

  logic            slot_live [SlotsDef];
  logic [KeyW-1:0] slot_tag  [SlotsDef];
  int unsigned     slot_cnt  [SlotsDef];

  outcome_t        expected_q [$];
  logic [KeyW-1:0] key_pool [KeyPoolSize];
  int unsigned     n_errors        = 0;
  int unsigned     n_requests      = 0;
  int unsigned     n_results       = 0;
  int unsigned     idle_cycles     = 0;
  int unsigned     sender_idle_pct = 0;
  int unsigned     op_seen [8];

  keyed_slot_trial_table_unit u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .opcode_i        (opcode_i),
    .key_id_i        (key_id_i),
    .restore_count_i (restore_count_i),
    .done_o          (done_o),
    .ok_o            (ok_o),
    .slot_index_o    (slot_index_o),
    .slot_trials_o   (slot_trials_o),
    .first_trial_o   (first_trial_o),
    .total_trials_o  (total_trials_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic int match_slot(logic [KeyW-1:0] key);
    for (int i = 0; i < SlotsDef; i++) begin
      if (slot_live[i] && slot_tag[i] == key) return i;
    end
    return -1;
  endfunction

  function automatic int free_slot();
    for (int i = 0; i < SlotsDef; i++) begin
      if (!slot_live[i]) return i;
    end
    return -1;
  endfunction

  function automatic int target_slot(logic [KeyW-1:0] key);
    int m;
    m = match_slot(key);
    return (m >= 0) ? m : free_slot();
  endfunction

  // table update plus the result the command should give
  function automatic outcome_t apply_cmd(opcode_e op, logic [KeyW-1:0] key,
                                         logic [RcW-1:0] rc);
    outcome_t    res;
    int          t;
    int unsigned sum;
    res = '0;
    sum = 0;
    case (op)
      OP_REGISTER: begin
        t = target_slot(key);
        if (t >= 0) begin
          slot_live[t] = 1'b1;
          slot_tag[t]  = key;
          slot_cnt[t]  = 1;
          res.ok       = 1'b1;
          res.idx      = IdxOutW'(t);
          res.trials   = TrOutW'(1);
        end
      end
      OP_APPEND: begin
        t = target_slot(key);
        if (t >= 0 && slot_cnt[t] + SetSizeDef <= MaxTrialsDef) begin
          res.first    = FirstOutW'(slot_cnt[t]);
          slot_live[t] = 1'b1;
          slot_tag[t]  = key;
          slot_cnt[t]  = slot_cnt[t] + SetSizeDef;
          res.ok       = 1'b1;
          res.idx      = IdxOutW'(t);
          res.trials   = TrOutW'(slot_cnt[t]);
        end
      end
      OP_CAN_APPEND: begin
        t = match_slot(key);
        if (t >= 0) begin
          if (slot_cnt[t] + SetSizeDef <= MaxTrialsDef) begin
            res.ok     = 1'b1;
            res.idx    = IdxOutW'(t);
            res.trials = TrOutW'(slot_cnt[t]);
            res.first  = FirstOutW'(slot_cnt[t]);
          end
        end else begin
          t = free_slot();
          if (t >= 0) begin
            res.ok  = 1'b1;
            res.idx = IdxOutW'(t);
          end
        end
      end
      OP_RESTORE: begin
        if (rc != 0 && rc <= MaxTrialsDef) begin
          t = target_slot(key);
          if (t >= 0) begin
            slot_live[t] = 1'b1;
            slot_tag[t]  = key;
            slot_cnt[t]  = 32'(rc);
            res.ok       = 1'b1;
            res.idx      = IdxOutW'(t);
            res.trials   = rc;
          end
        end
      end
      OP_REMOVE: begin
        t = match_slot(key);
        if (t >= 0) begin
          slot_live[t] = 1'b0;
          slot_tag[t]  = '0;
          slot_cnt[t]  = 0;
          res.ok       = 1'b1;
          res.idx      = IdxOutW'(t);
        end
      end
      OP_CLEAR: begin
        for (int i = 0; i < SlotsDef; i++) begin
          slot_live[i] = 1'b0;
          slot_tag[i]  = '0;
          slot_cnt[i]  = 0;
        end
        res.ok = 1'b1;
      end
      OP_FIND: begin
        t = match_slot(key);
        if (t >= 0) begin
          res.ok     = 1'b1;
          res.idx    = IdxOutW'(t);
          res.trials = TrOutW'(slot_cnt[t]);
        end
      end
      default: begin
        for (int i = 0; i < SlotsDef; i++) begin
          if (slot_live[i]) sum += slot_cnt[i];
        end
        res.ok    = 1'b1;
        res.total = TotW'(sum);
      end
    endcase
    return res;
  endfunction

  task automatic flag_mismatch(string what);
    n_errors++;
    $display("ERROR t=%0t result %0d: %s", $time, n_results, what);
  endtask

  // leaves start high on return unless an idle gap was taken
  task automatic send_cmd(opcode_e op, logic [KeyW-1:0] key, logic [RcW-1:0] rc);
    outcome_t exp_res;
    start           <= 1'b1;
    opcode_i        <= op;
    key_id_i        <= key;
    restore_count_i <= rc;
    do @(posedge clk_i); while (busy);
    exp_res    = apply_cmd(op, key, rc);
    expected_q = {expected_q, exp_res};
    n_requests++;
    op_seen[op]++;
    if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 24)) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_single_slot_ops();
    send_cmd(OP_TOTAL, '0, '0);
    send_cmd(OP_FIND, '0, '0);
    send_cmd(OP_REGISTER, '0, '0);
    send_cmd(OP_APPEND, '0, '1);
    send_cmd(OP_APPEND, 32'h5A5A_A5A5, '0);
    send_cmd(OP_CAN_APPEND, '0, '0);
    send_cmd(OP_RESTORE, 32'h0000_1234, 5'd0);
    send_cmd(OP_RESTORE, 32'h0000_1234, 5'd31);
    send_cmd(OP_REMOVE, '0, '0);
    send_cmd(OP_REMOVE, '0, '0);
    send_cmd(OP_CAN_APPEND, 32'h0000_1234, '0);
    send_cmd(OP_TOTAL, '0, '0);
    send_cmd(OP_CLEAR, '0, '0);
    wait_drained();
  endtask

  // every slot at the trial ceiling: full-table misses, overflow, top total
  task automatic test_full_table();
    for (int i = 0; i < SlotsDef; i++) begin
      send_cmd(OP_RESTORE, (i == 0) ? '1 : KeyW'(i), 5'd16);
    end
    send_cmd(OP_TOTAL, '0, '0);
    send_cmd(OP_REGISTER, 32'hDEAD_0001, '0);
    send_cmd(OP_CAN_APPEND, '1, '0);
    send_cmd(OP_APPEND, '1, '0);
    wait_drained();
  endtask

  task automatic test_random_traffic(int unsigned n_items);
    opcode_e         op;
    logic [KeyW-1:0] key;
    logic [RcW-1:0]  rc;
    for (int unsigned n = 0; n < n_items; n++) begin
      op = opcode_e'($urandom_range(7));
      // clear is kept rare so the table gets full
      if (op == OP_CLEAR && $urandom_range(9) != 0) op = OP_APPEND;
      key = ($urandom_range(9) != 0) ? key_pool[$urandom_range(KeyPoolSize - 1)]
                                     : $urandom();
      rc  = ($urandom_range(4) != 0) ? RcW'($urandom_range(1, MaxTrialsDef))
                                     : RcW'($urandom_range(31));
      send_cmd(op, key, rc);
    end
    wait_drained();
  endtask

  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni && done_o) begin
      if (expected_q.size() == 0) begin
        flag_mismatch("result with no request outstanding");
      end else begin
        want = expected_q.pop_front();
        if (ok_o !== want.ok)
          flag_mismatch($sformatf("ok exp %0d got %0d", want.ok, ok_o));
        if (slot_index_o !== want.idx)
          flag_mismatch($sformatf("slot_index exp %0d got %0d", want.idx, slot_index_o));
        if (slot_trials_o !== want.trials)
          flag_mismatch($sformatf("slot_trials exp %0d got %0d", want.trials, slot_trials_o));
        if (first_trial_o !== want.first)
          flag_mismatch($sformatf("first_trial exp %0d got %0d", want.first, first_trial_o));
        if (total_trials_o !== want.total)
          flag_mismatch($sformatf("total_trials exp %0d got %0d", want.total, total_trials_o));
      end
      n_results++;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < SlotsDef; i++) begin
      slot_live[i] = 1'b0;
      slot_tag[i]  = '0;
      slot_cnt[i]  = 0;
    end
    for (int i = 0; i < 8; i++) op_seen[i] = 0;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < KeyPoolSize; i++) key_pool[i] = $urandom();

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_single_slot_ops();
    test_full_table();
    sender_idle_pct = 20;
    test_random_traffic(ItemsPerPhase);
    sender_idle_pct = 48;
    test_random_traffic(ItemsPerPhase);
    sender_idle_pct = 0;
    test_random_traffic(ItemsPerPhase);

    repeat (SettleCycles) @(posedge clk_i);
    $display("summary: %0d requests sent, %0d results checked, %0d mismatches",
             n_requests, n_results, n_errors);
    $display("per opcode: reg %0d app %0d can %0d rst %0d rem %0d clr %0d find %0d tot %0d",
             op_seen[OP_REGISTER], op_seen[OP_APPEND], op_seen[OP_CAN_APPEND],
             op_seen[OP_RESTORE], op_seen[OP_REMOVE], op_seen[OP_CLEAR],
             op_seen[OP_FIND], op_seen[OP_TOTAL]);
    if (n_errors == 0 && expected_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/kstt_pkg.sv
hdl/kstt_ram.sv
hdl/keyed_slot_trial_table_unit.sv
sim/keyed_slot_trial_table_unit_tb.sv
